### rtl/xbr_pkg.sv
package xbr_pkg;

   localparam int CNT_W = 11;

   localparam logic [7:0] CHR_SOH = 8'h01;
   localparam logic [7:0] CHR_STX = 8'h02;
   localparam logic [7:0] CHR_EOT = 8'h04;
   localparam logic [7:0] CHR_ACK = 8'h06;
   localparam logic [7:0] CHR_NAK = 8'h15;
   localparam logic [7:0] CHR_CR  = 8'h0D;
   localparam logic [7:0] CHR_LF  = 8'h0A;
   localparam logic [7:0] CHR_C   = 8'h43;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [CNT_W-1:0] SHORT_LEN = CNT_W'(128);
   localparam logic [CNT_W-1:0] LONG_LEN  = CNT_W'(1024);
   localparam logic [CNT_W-1:0] SHORT_END = SHORT_LEN + CNT_W'(3);
   localparam logic [CNT_W-1:0] LONG_END  = LONG_LEN + CNT_W'(3);
   localparam logic [CNT_W-1:0] POS_NUM   = CNT_W'(1);
   localparam logic [CNT_W-1:0] POS_INV   = CNT_W'(2);
   localparam logic [CNT_W-1:0] POS_DATA  = CNT_W'(3);

   localparam logic REG_USE_CRC = 1'b0;

   typedef struct packed {
      logic       reply_valid;
      logic [7:0] reply_byte;
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       block_accepted;
      logic       block_rejected;
      logic       transfer_done;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      logic    two;
      rsp_type rsp;
   } load_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

### rtl/xbr_csr.sv
module xbr_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic        use_crc
);

   logic use_crc_ff;
   logic use_crc_in;
   logic wr;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;

   always_comb begin
      use_crc_in = use_crc_ff;
      prdata = 32'h0;
      unique case (paddr[2])
         xbr_pkg::REG_USE_CRC: begin
            prdata = {31'h0, use_crc_ff};
            if (wr) begin
               use_crc_in = pwdata[0];
            end
         end
         default: begin
            prdata = 32'h0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_crc_ff <= 1'b0;
      end else begin
         use_crc_ff <= use_crc_in;
      end
   end

   assign use_crc = use_crc_ff;

endmodule

### rtl/xbr_core.sv
module xbr_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [7:0]        req_byte_in,
   input  logic              use_crc,
   input  logic              out_free,
   output xbr_pkg::load_type load
);

   localparam int W = xbr_pkg::CNT_W;

   logic         in_valid_ff, in_valid_in;
   logic         func_ff, func_in;
   logic [7:0]   byte_ff, byte_in;
   logic         adv;
   logic         accept;

   logic         receiving_ff, receiving_in;
   logic [W-1:0] count_ff, count_in;
   logic         long_ff, long_in;
   logic [7:0]   num_ff, num_in;
   logic [7:0]   inv_ff, inv_in;
   logic [15:0]  crc_ff, crc_in;
   logic [7:0]   sum_ff, sum_in;
   logic [7:0]   crc_hi_ff, crc_hi_in;

   logic [W-1:0] block_end;
   logic         ok;
   xbr_pkg::load_type res;

   assign adv       = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = accept ? 1'b1 : (adv ? 1'b0 : in_valid_ff);
      func_in     = accept ? req_func : func_ff;
      byte_in     = accept ? req_byte_in : byte_ff;
   end

   assign block_end = long_ff ? xbr_pkg::LONG_END : xbr_pkg::SHORT_END;

   always_comb begin
      if (use_crc) begin
         ok = (crc_hi_ff == crc_ff[15:8]) && (byte_ff == crc_ff[7:0]);
      end else begin
         ok = (num_ff == ~inv_ff) && (byte_ff == sum_ff);
      end
   end

   always_comb begin
      receiving_in = receiving_ff;
      count_in     = count_ff;
      long_in      = long_ff;
      num_in       = num_ff;
      inv_in       = inv_ff;
      crc_in       = crc_ff;
      sum_in       = sum_ff;
      crc_hi_in    = crc_hi_ff;
      res          = '0;
      if (func_ff) begin
         receiving_in         = 1'b1;
         count_in             = '0;
         crc_in               = '0;
         sum_in               = '0;
         res.valid            = 1'b1;
         res.rsp.reply_valid  = 1'b1;
         res.rsp.reply_byte   = use_crc ? xbr_pkg::CHR_C : xbr_pkg::CHR_NAK;
         res.rsp.last         = 1'b1;
      end else if (!receiving_ff) begin
         res.valid            = 1'b1;
         res.rsp.reply_valid  = 1'b1;
         res.rsp.reply_byte   = byte_ff;
         res.two              = (byte_ff == xbr_pkg::CHR_CR);
         res.rsp.last         = (byte_ff != xbr_pkg::CHR_CR);
      end else if (count_ff == '0) begin
         if (byte_ff == xbr_pkg::CHR_SOH || byte_ff == xbr_pkg::CHR_STX) begin
            long_in  = (byte_ff == xbr_pkg::CHR_STX);
            count_in = xbr_pkg::POS_NUM;
            crc_in   = '0;
            sum_in   = '0;
         end else if (byte_ff == xbr_pkg::CHR_EOT) begin
            receiving_in          = 1'b0;
            res.valid             = 1'b1;
            res.rsp.reply_valid   = 1'b1;
            res.rsp.reply_byte    = xbr_pkg::CHR_ACK;
            res.rsp.transfer_done = 1'b1;
            res.rsp.last          = 1'b1;
         end
      end else if (count_ff == xbr_pkg::POS_NUM) begin
         num_in   = byte_ff;
         count_in = xbr_pkg::POS_INV;
      end else if (count_ff == xbr_pkg::POS_INV) begin
         inv_in   = byte_ff;
         count_in = xbr_pkg::POS_DATA;
      end else if (count_ff < block_end) begin
         crc_in                = xbr_pkg::crc_byte(crc_ff, byte_ff);
         sum_in                = sum_ff + byte_ff;
         count_in              = count_ff + W'(1);
         res.valid             = 1'b1;
         res.rsp.payload_valid = 1'b1;
         res.rsp.payload_byte  = byte_ff;
         res.rsp.last          = 1'b1;
      end else if (use_crc && count_ff == block_end) begin
         crc_hi_in = byte_ff;
         count_in  = count_ff + W'(1);
      end else begin
         count_in               = '0;
         res.valid              = 1'b1;
         res.rsp.reply_valid    = 1'b1;
         res.rsp.reply_byte     = ok ? xbr_pkg::CHR_ACK : xbr_pkg::CHR_NAK;
         res.rsp.block_accepted = ok;
         res.rsp.block_rejected = !ok;
         res.rsp.last           = 1'b1;
      end
   end

   always_comb begin
      load       = res;
      load.valid = res.valid && adv;
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      byte_ff <= byte_in;
      if (reset) begin
         in_valid_ff  <= 1'b0;
         receiving_ff <= 1'b0;
         count_ff     <= '0;
         long_ff      <= 1'b0;
         num_ff       <= '0;
         inv_ff       <= '0;
         crc_ff       <= '0;
         sum_ff       <= '0;
         crc_hi_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (adv) begin
            receiving_ff <= receiving_in;
            count_ff     <= count_in;
            long_ff      <= long_in;
            num_ff       <= num_in;
            inv_ff       <= inv_in;
            crc_ff       <= crc_in;
            sum_ff       <= sum_in;
            crc_hi_ff    <= crc_hi_in;
         end
      end
   end

endmodule

### rtl/xbr_out.sv
module xbr_out (
   input  logic              clock,
   input  logic              reset,
   input  xbr_pkg::load_type load,
   output logic              out_free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output xbr_pkg::rsp_type  rsp
);

   logic             out_valid_ff, out_valid_in;
   logic             lf_ff, lf_in;
   xbr_pkg::rsp_type out_ff, out_in;
   xbr_pkg::rsp_type lf_rsp;
   logic             take;

   assign take     = out_valid_ff && !rsp_stall;
   assign out_free = !out_valid_ff || (take && !lf_ff);

   always_comb begin
      lf_rsp             = '0;
      lf_rsp.reply_valid = 1'b1;
      lf_rsp.reply_byte  = xbr_pkg::CHR_LF;
      lf_rsp.last        = 1'b1;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      lf_in        = lf_ff;
      out_in       = out_ff;
      if (load.valid) begin
         out_valid_in = 1'b1;
         lf_in        = load.two;
         out_in       = load.rsp;
      end else if (take && lf_ff) begin
         lf_in  = 1'b0;
         out_in = lf_rsp;
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
         lf_ff        <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         lf_ff        <= lf_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

`ifndef SYNTHESIS
   a_lf_needs_echo: assert property (@(posedge clock) disable iff (reset)
      lf_ff |-> (out_valid_ff && !out_ff.last))
      else $error("lf pending without a first echo item");
   a_lf_follows: assert property (@(posedge clock) disable iff (reset)
      (take && lf_ff) |=> (out_valid_ff && out_ff.reply_byte == xbr_pkg::CHR_LF
                           && out_ff.last))
      else $error("lf item did not follow cr echo");
   a_verdict_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.block_accepted && out_ff.block_rejected))
      else $error("block both accepted and rejected");
   a_reply_or_payload: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.reply_valid && out_ff.payload_valid))
      else $error("item carries reply and payload together");
`endif

endmodule

### rtl/xmodem_block_receiver_unit.sv
// xmodem block receiver
// req channel: one item per received byte (req_func = 0) or a start command
// (req_func = 1); accepted when req_valid is high and req_stall is low.
// rsp channel: result items with reply byte to the sender, tentative payload
// byte and block verdict flags; rsp_last marks the final result of an input item.
// config: use_crc at address 0 selects crc-16 check and 'C' start; write it
// only while no item is in flight.
// path: an accepted input item waits in the input register, then its result in the
// result register, from which it is taken when rsp_stall is low.
// throughput: one input item per cycle while rsp_stall is low; a cr in echo mode
// yields two results (cr, then lf), so it holds the result register until both are taken.
// input items that cause no result (header bytes, ignored bytes) leave the
// input register at the next edge at which the result register is free.
// when rsp_stall is high the result register holds and one more item can
// wait in the input register; req_stall then rises until the result drains.
// reset (synchronous) returns to echo mode, clears the block state and
// use_crc, and empties both registers.
module xmodem_block_receiver_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_reply_valid,
   output logic [7:0]  rsp_reply_byte,
   output logic        rsp_payload_valid,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_block_accepted,
   output logic        rsp_block_rejected,
   output logic        rsp_transfer_done,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic              use_crc;
   logic              out_free;
   xbr_pkg::load_type load;
   xbr_pkg::rsp_type  rsp;

   xbr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .use_crc (use_crc)
   );

   xbr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_byte_in (req_byte_in),
      .use_crc     (use_crc),
      .out_free    (out_free),
      .load        (load)
   );

   xbr_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_reply_valid    = rsp.reply_valid;
   assign rsp_reply_byte     = rsp.reply_byte;
   assign rsp_payload_valid  = rsp.payload_valid;
   assign rsp_payload_byte   = rsp.payload_byte;
   assign rsp_block_accepted = rsp.block_accepted;
   assign rsp_block_rejected = rsp.block_rejected;
   assign rsp_transfer_done  = rsp.transfer_done;
   assign rsp_last           = rsp.last;

endmodule

### tb/testbench.sv
module testbench;

   localparam int ITEM_TARGET = 1550;
   localparam int LIMIT = 300000;
   localparam int DRAIN_GAP = 6;
   localparam int MAX_REPORTS = 10;
   localparam logic [2:0] ADDR_USE_CRC = 3'(4 * xbr_pkg::REG_USE_CRC);
   localparam logic [7:0] SPECIALS [0:5] = '{8'h00, 8'hFF, xbr_pkg::CHR_SOH,
                                             xbr_pkg::CHR_STX, xbr_pkg::CHR_EOT,
                                             xbr_pkg::CHR_CR};

   typedef enum logic [1:0] {ROW_BYTE, ROW_START, ROW_MODE} row_type;
   typedef enum logic [1:0] {FLAW_NONE, FLAW_INV, FLAW_HI, FLAW_CHK} blk_flaw_type;

   typedef struct packed {
      row_type    kind;
      logic [7:0] data;
      logic       known;
      logic [7:0] reply;
      logic       done;
   } plan_row_type;

   localparam int PLAN_LEN = 24;
   localparam plan_row_type PLAN [0:PLAN_LEN-1] = '{
      '{ROW_BYTE,  8'h00,            1'b1, 8'h00,            1'b0},
      '{ROW_BYTE,  8'hFF,            1'b1, 8'hFF,            1'b0},
      '{ROW_BYTE,  xbr_pkg::CHR_CR,  1'b0, 8'h00,            1'b0},
      '{ROW_BYTE,  xbr_pkg::CHR_LF,  1'b1, xbr_pkg::CHR_LF,  1'b0},
      '{ROW_START, 8'hA5,            1'b1, xbr_pkg::CHR_NAK, 1'b0},
      '{ROW_BYTE,  8'h33,            1'b0, 8'h00,            1'b0},
      '{ROW_BYTE,  xbr_pkg::CHR_SOH, 1'b0, 8'h00,            1'b0},
      '{ROW_BYTE,  8'h01,            1'b0, 8'h00,            1'b0},
      '{ROW_BYTE,  8'hFE,            1'b0, 8'h00,            1'b0},
      '{ROW_BYTE,  8'h00,            1'b0, 8'h00,            1'b0},
      '{ROW_BYTE,  8'hFF,            1'b0, 8'h00,            1'b0},
      '{ROW_START, 8'h00,            1'b1, xbr_pkg::CHR_NAK, 1'b0},
      '{ROW_BYTE,  xbr_pkg::CHR_EOT, 1'b1, xbr_pkg::CHR_ACK, 1'b1},
      '{ROW_MODE,  8'h01,            1'b0, 8'h00,            1'b0},
      '{ROW_START, 8'hFF,            1'b1, xbr_pkg::CHR_C,   1'b0},
      '{ROW_BYTE,  xbr_pkg::CHR_STX, 1'b0, 8'h00,            1'b0},
      '{ROW_BYTE,  8'h7E,            1'b0, 8'h00,            1'b0},
      '{ROW_BYTE,  8'h80,            1'b0, 8'h00,            1'b0},
      '{ROW_BYTE,  xbr_pkg::CHR_CR,  1'b0, 8'h00,            1'b0},
      '{ROW_START, 8'h5A,            1'b1, xbr_pkg::CHR_C,   1'b0},
      '{ROW_BYTE,  xbr_pkg::CHR_EOT, 1'b1, xbr_pkg::CHR_ACK, 1'b1},
      '{ROW_BYTE,  xbr_pkg::CHR_CR,  1'b0, 8'h00,            1'b0},
      '{ROW_BYTE,  8'h80,            1'b1, 8'h80,            1'b0},
      '{ROW_MODE,  8'h00,            1'b0, 8'h00,            1'b0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = 1'b0;
   logic [7:0]  req_byte_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_reply_valid;
   logic [7:0]  rsp_reply_byte;
   logic        rsp_payload_valid;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_block_accepted;
   logic        rsp_block_rejected;
   logic        rsp_transfer_done;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'b000;
   logic [31:0] pwdata = 32'h0;
   logic [31:0] prdata;
   logic        pready;

   // receiver state as predicted
   logic                      mode_crc = 1'b0;
   logic                      rx_on = 1'b0;
   logic [xbr_pkg::CNT_W-1:0] blk_pos = '0;
   logic                      blk_long = 1'b0;
   logic [7:0]                blk_num = 8'h00;
   logic [7:0]                blk_num_inv = 8'h00;
   logic [15:0]               blk_crc = 16'h0000;
   logic [7:0]                blk_sum = 8'h00;
   logic [7:0]                crc_hi_seen = 8'h00;

   xbr_pkg::rsp_type step_out [0:1];
   int               step_n;
   xbr_pkg::rsp_type due_results [$];

   logic jitter = 1'b1;
   int   errors = 0;
   int   cycles = 0;
   int   items_sent = 0;
   int   n_checked = 0;
   int   n_acc = 0;
   int   n_rej = 0;
   int   n_phases = 0;
   bit   long_done = 1'b0;

   xmodem_block_receiver_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_byte_in        (req_byte_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_reply_valid    (rsp_reply_valid),
      .rsp_reply_byte     (rsp_reply_byte),
      .rsp_payload_valid  (rsp_payload_valid),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_block_accepted (rsp_block_accepted),
      .rsp_block_rejected (rsp_block_rejected),
      .rsp_transfer_done  (rsp_transfer_done),
      .rsp_last           (rsp_last),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic xbr_pkg::rsp_type mk_rsp(logic rv, logic [7:0] rb, logic pv,
                                               logic [7:0] pb, logic acc, logic rej,
                                               logic done, logic lst);
      return '{rv, rb, pv, pb, acc, rej, done, lst};
   endfunction

   function automatic string fmt_rsp(xbr_pkg::rsp_type r);
      return $sformatf("rv=%0b rb=%02h pv=%0b pb=%02h acc=%0b rej=%0b done=%0b last=%0b",
                       r.reply_valid, r.reply_byte, r.payload_valid, r.payload_byte,
                       r.block_accepted, r.block_rejected, r.transfer_done, r.last);
   endfunction

   // msb-first, one input bit per step
   function automatic logic [15:0] crc16_next(logic [15:0] c, logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ d[i];
         c = {c[14:0], 1'b0} ^ (fb ? xbr_pkg::CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   function automatic logic [7:0] spoil(bit on);
      return on ? 8'($urandom_range(255, 1)) : 8'h00;
   endfunction

   // advances the predicted state by one item, results land in step_out
   function automatic int receiver_step(logic f, logic [7:0] b);
      logic [xbr_pkg::CNT_W-1:0] blk_end;
      logic                      good;
      blk_end = blk_long ? xbr_pkg::LONG_END : xbr_pkg::SHORT_END;
      if (f) begin
         rx_on = 1'b1;
         blk_pos = '0;
         blk_crc = 16'h0000;
         blk_sum = 8'h00;
         step_out[0] = mk_rsp(1'b1, mode_crc ? xbr_pkg::CHR_C : xbr_pkg::CHR_NAK, 1'b0,
                              8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
         return 1;
      end
      if (!rx_on) begin
         if (b == xbr_pkg::CHR_CR) begin
            step_out[0] = mk_rsp(1'b1, b, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
            step_out[1] = mk_rsp(1'b1, xbr_pkg::CHR_LF, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0,
                                 1'b1);
            return 2;
         end
         step_out[0] = mk_rsp(1'b1, b, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
         return 1;
      end
      if (blk_pos == '0) begin
         if (b == xbr_pkg::CHR_SOH || b == xbr_pkg::CHR_STX) begin
            blk_long = (b == xbr_pkg::CHR_STX);
            blk_pos = xbr_pkg::POS_NUM;
            blk_crc = 16'h0000;
            blk_sum = 8'h00;
            return 0;
         end
         if (b == xbr_pkg::CHR_EOT) begin
            rx_on = 1'b0;
            step_out[0] = mk_rsp(1'b1, xbr_pkg::CHR_ACK, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1,
                                 1'b1);
            return 1;
         end
         return 0;
      end
      if (blk_pos == xbr_pkg::POS_NUM) begin
         blk_num = b;
         blk_pos = xbr_pkg::POS_INV;
         return 0;
      end
      if (blk_pos == xbr_pkg::POS_INV) begin
         blk_num_inv = b;
         blk_pos = xbr_pkg::POS_DATA;
         return 0;
      end
      if (blk_pos < blk_end) begin
         blk_crc = crc16_next(blk_crc, b);
         blk_sum = blk_sum + b;
         blk_pos = blk_pos + 1'b1;
         step_out[0] = mk_rsp(1'b0, 8'h00, 1'b1, b, 1'b0, 1'b0, 1'b0, 1'b1);
         return 1;
      end
      if (mode_crc && blk_pos == blk_end) begin
         crc_hi_seen = b;
         blk_pos = blk_pos + 1'b1;
         return 0;
      end
      if (mode_crc)
         good = (crc_hi_seen == blk_crc[15:8]) && (b == blk_crc[7:0]);
      else
         good = (blk_num == ~blk_num_inv) && (b == blk_sum);
      blk_pos = '0;
      step_out[0] = mk_rsp(1'b1, good ? xbr_pkg::CHR_ACK : xbr_pkg::CHR_NAK, 1'b0, 8'h00,
                           good, !good, 1'b0, 1'b1);
      return 1;
   endfunction

   task automatic send_req(logic f, logic [7:0] b, bit counts = 1'b1);
      bit took;
      int n;
      while (jitter && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_byte_in <= b;
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
      n = receiver_step(f, b);
      for (int k = 0; k < n; k++)
         due_results = {due_results, step_out[k]};
      step_n = n;
      if (counts)
         items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (due_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   task automatic csr_write(logic v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_USE_CRC;
      pwdata <= {31'b0, v};
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (!pready);
      @(posedge clock);
      mode_crc = v;
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (!pready);
      if (prdata !== {31'b0, v}) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("use_crc read back %08h, written %0b", prdata, v);
      end
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // one block from opening byte to verdict; split flips use_crc before the final check byte
   task automatic send_block(bit long_blk, bit split);
      blk_flaw_type flaw;
      logic [7:0]   num;
      logic [7:0]   tail;
      flaw = ($urandom_range(99) < 55) ? FLAW_NONE : blk_flaw_type'($urandom_range(3, 1));
      num = 8'($urandom);
      send_req(1'b0, long_blk ? xbr_pkg::CHR_STX : xbr_pkg::CHR_SOH);
      send_req(1'b0, num);
      send_req(1'b0, ~num ^ spoil(flaw == FLAW_INV));
      for (int i = 0; i < int'(long_blk ? xbr_pkg::LONG_LEN : xbr_pkg::SHORT_LEN); i++)
         send_req(1'b0, ($urandom_range(7) == 0) ? SPECIALS[$urandom_range(5)]
                                                  : 8'($urandom));
      if (split) begin
         if (mode_crc)
            send_req(1'b0, blk_crc[15:8] ^ spoil(flaw == FLAW_HI));
         drain();
         csr_write(!mode_crc);
      end
      if (mode_crc && blk_pos == (blk_long ? xbr_pkg::LONG_END : xbr_pkg::SHORT_END))
         send_req(1'b0, blk_crc[15:8] ^ spoil(flaw == FLAW_HI));
      tail = mode_crc ? blk_crc[7:0] : blk_sum;
      send_req(1'b0, tail ^ spoil(flaw == FLAW_CHK));
   endtask

   always @(posedge clock)
      rsp_stall <= !reset && jitter && ($urandom_range(99) < 11);

   always @(negedge clock) begin : result_check
      xbr_pkg::rsp_type got;
      xbr_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_reply_valid, rsp_reply_byte, rsp_payload_valid, rsp_payload_byte,
                 rsp_block_accepted, rsp_block_rejected, rsp_transfer_done, rsp_last};
         if (due_results.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("cycle %0d: result with none expected: %s", cycles, fmt_rsp(got));
         end else begin
            want = due_results.pop_front();
            n_checked++;
            if (want.block_accepted)
               n_acc++;
            if (want.block_rejected)
               n_rej++;
            if (got !== want) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("cycle %0d: expected %s\n          got      %s",
                           cycles, fmt_rsp(want), fmt_rsp(got));
            end
         end
      end
   end

   initial begin : watchdog
      while (cycles < LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               due_results.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      int         pick;
      logic [7:0] b;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < PLAN_LEN; i++) begin
         case (PLAN[i].kind)
            ROW_MODE: begin
               drain();
               csr_write(PLAN[i].data[0]);
            end
            default: begin
               send_req(PLAN[i].kind == ROW_START, PLAN[i].data);
               if (PLAN[i].known) begin
                  repeat (step_n) void'(due_results.pop_back());
                  due_results = {due_results, mk_rsp(1'b1, PLAN[i].reply, 1'b0, 8'h00,
                                                     1'b0, 1'b0, PLAN[i].done, 1'b1)};
               end
            end
         endcase
      end

      while (items_sent < ITEM_TARGET) begin
         drain();
         jitter <= (n_phases != 2);
         csr_write(n_phases[0]);
         n_phases++;
         send_req(1'b1, 8'($urandom));
         repeat ($urandom_range(4, 2)) begin
            pick = $urandom_range(99);
            if (!long_done && items_sent > 400) begin
               send_block(1'b1, 1'b0);
               long_done = 1'b1;
            end else if (pick < 55) begin
               send_block(1'b0, $urandom_range(99) < 20);
            end else if (pick < 65) begin
               // noise between blocks
               repeat ($urandom_range(3, 1)) begin
                  do b = 8'($urandom);
                  while (b == xbr_pkg::CHR_SOH || b == xbr_pkg::CHR_STX ||
                         b == xbr_pkg::CHR_EOT);
                  send_req(1'b0, b);
               end
            end else if (pick < 78) begin
               // block cut short by a fresh start command
               send_req(1'b0, $urandom_range(1) ? xbr_pkg::CHR_STX : xbr_pkg::CHR_SOH);
               repeat ($urandom_range(6)) send_req(1'b0, 8'($urandom));
               send_req(1'b1, 8'($urandom));
            end else if (pick < 92) begin
               send_req(1'b0, xbr_pkg::CHR_EOT);
               repeat ($urandom_range(8, 2))
                  send_req(1'b0, ($urandom_range(3) == 0) ? xbr_pkg::CHR_CR : 8'($urandom));
               send_req(1'b1, 8'($urandom));
            end else begin
               send_req(1'b1, 8'($urandom));
            end
         end
      end

      drain();
      $display("sent %0d items over %0d mode phases, checked %0d results in %0d cycles",
               items_sent, n_phases, n_checked, cycles);
      $display("block verdicts: %0d accepted, %0d rejected, long block covered: %0d",
               n_acc, n_rej, long_done);
      if (errors == 0 && due_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
